// File: rtl/pidc_pkg.sv
// Shared types, constants and helper functions of the PID position controller.
package pidc_pkg;

    localparam logic [20:0] DT_DEFAULT_US = 21'd1000;
    localparam logic [20:0] DT_MAX_US     = 21'd1000000;
    localparam logic [19:0] US_PER_S      = 20'd1000000;
    localparam logic [31:0] RECIP_US      = 32'd2251799813;
    localparam int          DIV_W         = 54;
    localparam logic [5:0]  DIV_STEPS     = 6'd54;

    localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [2:0] REG_INTEG_UPPER    = 3'd3;
    localparam logic [2:0] REG_INTEG_LOWER    = 3'd4;
    localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd5;
    localparam logic [2:0] REG_TARGET_FLOOR   = 3'd6;
    localparam logic [2:0] REG_TARGET_CEILING = 3'd7;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain;
        logic signed [31:0] integ_upper;
        logic signed [31:0] integ_lower;
        logic        [30:0] drive_limit;
        logic signed [31:0] target_floor;
        logic signed [31:0] target_ceiling;
    } cfg_t;

    typedef struct packed {
        logic               ig_wr;
        logic               dg_wr;
        logic signed [31:0] wdata;
    } cfg_evt_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ERR, ST_MRATE, ST_DGO1, ST_DSTEP1, ST_TRATE,
        ST_MP, ST_TP, ST_MD, ST_TD, ST_MI, ST_TI, ST_MIS,
        ST_TIS, ST_MRQ, ST_TRQ, ST_MQC, ST_TSTEP, ST_FIN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_ERR, OP_MUL, OP_TAKE, OP_DIV_GO, OP_DIV_STEP, OP_FIN
    } dp_op_t;

    typedef enum logic [2:0] {
        SEL_RATE, SEL_P, SEL_D, SEL_I, SEL_IS, SEL_RQ, SEL_QC
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        mag34 = v[33] ? (34'd0 - v) : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] m);
        if (neg) begin
            sat32 = (m > 64'h8000_0000) ? 32'sh8000_0000 : (32'd0 - m[31:0]);
        end else begin
            sat32 = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
        end
    endfunction

    function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                   input logic signed [33:0] lo,
                                                   input logic signed [33:0] hi);
        logic signed [33:0] r;
        r = v;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        clamp34 = r;
    endfunction

endpackage

// File: rtl/pidc_regs.sv
// Configuration register file with its APB-style port.
module pidc_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pidc_pkg::cfg_t    cfg,
    output pidc_pkg::cfg_evt_t evt
);
    import pidc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    assign evt.ig_wr = wr && (idx == REG_INTEG_GAIN);
    assign evt.dg_wr = wr && (idx == REG_DERIV_GAIN);
    assign evt.wdata = pwdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= 32'sd3932160;
            cfg_reg.integ_gain     <= 32'sd2621440;
            cfg_reg.deriv_gain     <= 32'sd0;
            cfg_reg.integ_upper    <= 32'sd32768000;
            cfg_reg.integ_lower    <= -32'sd32768000;
            cfg_reg.drive_limit    <= 31'd5242880;
            cfg_reg.target_floor   <= -32'sd205887;
            cfg_reg.target_ceiling <= 32'sd0;
        end else if (wr) begin
            unique case (idx)
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= pwdata;
                REG_INTEG_GAIN:     cfg_reg.integ_gain     <= pwdata;
                REG_DERIV_GAIN:     cfg_reg.deriv_gain     <= pwdata;
                REG_INTEG_UPPER:    cfg_reg.integ_upper    <= pwdata;
                REG_INTEG_LOWER:    cfg_reg.integ_lower    <= pwdata;
                REG_DRIVE_LIMIT:    cfg_reg.drive_limit    <= pwdata[30:0];
                REG_TARGET_FLOOR:   cfg_reg.target_floor   <= pwdata;
                REG_TARGET_CEILING: cfg_reg.target_ceiling <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PROP_GAIN:      prdata = cfg_reg.prop_gain;
            REG_INTEG_GAIN:     prdata = cfg_reg.integ_gain;
            REG_DERIV_GAIN:     prdata = cfg_reg.deriv_gain;
            REG_INTEG_UPPER:    prdata = cfg_reg.integ_upper;
            REG_INTEG_LOWER:    prdata = cfg_reg.integ_lower;
            REG_DRIVE_LIMIT:    prdata = {1'b0, cfg_reg.drive_limit};
            REG_TARGET_FLOOR:   prdata = cfg_reg.target_floor;
            REG_TARGET_CEILING: prdata = cfg_reg.target_ceiling;
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/pidc_ctrl.sv
// Controller state machine that sequences one control update.
module pidc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_kind,
    output logic                  s_tready,
    input  pidc_pkg::dp_stat_t    stat,
    output pidc_pkg::dp_cmd_t     cmd,
    output pidc_pkg::ctrl_state_t state
);
    import pidc_pkg::*;

    ctrl_state_t state_reg, state_next;

    assign state    = state_reg;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid && s_kind) state_next = ST_ERR;
            ST_ERR:    state_next = ST_MRATE;
            ST_MRATE:  state_next = ST_DGO1;
            ST_DGO1:   state_next = ST_DSTEP1;
            ST_DSTEP1: if (stat.div_done) state_next = ST_TRATE;
            ST_TRATE:  state_next = ST_MP;
            ST_MP:     state_next = ST_TP;
            ST_TP:     state_next = ST_MD;
            ST_MD:     state_next = ST_TD;
            ST_TD:     state_next = ST_MI;
            ST_MI:     state_next = ST_TI;
            ST_TI:     state_next = ST_MIS;
            ST_MIS:    state_next = ST_TIS;
            ST_TIS:    state_next = ST_MRQ;
            ST_MRQ:    state_next = ST_TRQ;
            ST_TRQ:    state_next = ST_MQC;
            ST_MQC:    state_next = ST_TSTEP;
            ST_TSTEP:  state_next = ST_FIN;
            ST_FIN:    if (!stat.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NONE;
        cmd.sel = SEL_RATE;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) cmd.op = OP_LOAD;
            ST_ERR:    cmd.op = OP_ERR;
            ST_MRATE:  cmd = '{op: OP_MUL, sel: SEL_RATE};
            ST_DGO1:   cmd = '{op: OP_DIV_GO, sel: SEL_RATE};
            ST_DSTEP1: cmd.op = OP_DIV_STEP;
            ST_TRATE:  cmd = '{op: OP_TAKE, sel: SEL_RATE};
            ST_MP:     cmd = '{op: OP_MUL, sel: SEL_P};
            ST_TP:     cmd = '{op: OP_TAKE, sel: SEL_P};
            ST_MD:     cmd = '{op: OP_MUL, sel: SEL_D};
            ST_TD:     cmd = '{op: OP_TAKE, sel: SEL_D};
            ST_MI:     cmd = '{op: OP_MUL, sel: SEL_I};
            ST_TI:     cmd = '{op: OP_TAKE, sel: SEL_I};
            ST_MIS:    cmd = '{op: OP_MUL, sel: SEL_IS};
            ST_TIS:    cmd = '{op: OP_TAKE, sel: SEL_IS};
            ST_MRQ:    cmd = '{op: OP_MUL, sel: SEL_RQ};
            ST_TRQ:    cmd = '{op: OP_TAKE, sel: SEL_RQ};
            ST_MQC:    cmd = '{op: OP_MUL, sel: SEL_QC};
            ST_TSTEP:  cmd = '{op: OP_TAKE, sel: SEL_QC};
            ST_FIN:    if (!stat.out_busy) cmd.op = OP_FIN;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: rtl/pidc_dp.sv
// Datapath: controller state, shared multiplier, shared divider, result register.
module pidc_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pidc_pkg::dp_cmd_t         cmd,
    output pidc_pkg::dp_stat_t        stat,
    input  pidc_pkg::cfg_t            cfg,
    input  pidc_pkg::cfg_evt_t        evt,
    input  logic                      in_kind,
    input  logic signed [31:0]        in_target_cmd,
    input  logic signed [31:0]        in_measured_pos,
    input  logic [20:0]               in_elapsed_us,
    output logic signed [31:0]        out_drive_force,
    output logic signed [31:0]        out_pos_echo,
    output logic                      out_valid,
    input  logic                      out_ready
);
    import pidc_pkg::*;

    logic signed [31:0] held_reg, integ_reg, pos_reg;
    logic signed [32:0] last_reg, err_reg;
    logic               restart_reg;
    logic [20:0]        dt_reg;
    logic signed [33:0] diff_reg;
    logic [65:0]        prod_reg;
    logic               prod_neg_reg;
    logic signed [31:0] p_reg, d_reg, ie_reg, rate_reg;
    logic signed [32:0] step_reg;
    logic [20:0]        rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [19:0]        den_reg;
    logic [5:0]         cnt_reg;
    logic [50:0]        num_reg;
    logic [31:0]        qest_reg;
    logic signed [31:0] force_reg, echo_reg;
    logic               valid_reg;

    logic [33:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_neg;
    logic [33:0]        pg_mag, dg_mag, ig_mag;
    logic signed [31:0] tlo, thi, tgt;
    logic [20:0]        dt_fix;
    logic signed [32:0] err_now, last_eff;
    logic [20:0]        rem_sh;
    logic               ge;
    logic               ig_pos;
    logic signed [33:0] ilo, ihi, isum, cand, raw, lim, iclamp;
    logic               deeper, err_pos;
    logic [50:0]        rem_us;
    logic [1:0]         corr;
    logic [32:0]        qv;

    assign stat.div_done = (cnt_reg == 6'd0);
    assign stat.out_busy = valid_reg && !out_ready;
    assign out_drive_force = force_reg;
    assign out_pos_echo    = echo_reg;
    assign out_valid       = valid_reg;

    assign ig_pos = !cfg.integ_gain[31] && (cfg.integ_gain != 32'sd0);
    assign ilo    = 34'(cfg.integ_lower);
    assign ihi    = 34'(cfg.integ_upper);
    assign lim    = $signed({3'b000, cfg.drive_limit});
    assign pg_mag = mag34(34'(cfg.prop_gain));
    assign dg_mag = mag34(34'(cfg.deriv_gain));
    assign ig_mag = mag34(34'(cfg.integ_gain));
    assign iclamp = clamp34(34'(integ_reg), ilo, ihi);

    always_comb begin
        if (cfg.target_floor > cfg.target_ceiling) begin
            tlo = cfg.target_ceiling;
            thi = cfg.target_floor;
        end else begin
            tlo = cfg.target_floor;
            thi = cfg.target_ceiling;
        end
        tgt = in_target_cmd;
        if (tgt > thi) tgt = thi;
        if (tgt < tlo) tgt = tlo;
        dt_fix = ((in_elapsed_us == 21'd0) || (in_elapsed_us > DT_MAX_US)) ?
                 DT_DEFAULT_US : in_elapsed_us;
    end

    assign err_now  = 33'(held_reg) - 33'(pos_reg);
    assign last_eff = restart_reg ? err_now : last_reg;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.sel)
            SEL_RATE: begin
                mul_a = mag34(diff_reg);
                mul_b = {12'd0, US_PER_S};
            end
            SEL_P: begin
                mul_a   = mag34(34'(err_reg));
                mul_b   = pg_mag[31:0];
                mul_neg = err_reg[32] ^ cfg.prop_gain[31];
            end
            SEL_D: begin
                mul_a   = mag34(34'(rate_reg));
                mul_b   = dg_mag[31:0];
                mul_neg = rate_reg[31] ^ cfg.deriv_gain[31];
            end
            SEL_I: begin
                mul_a   = mag34(34'(err_reg));
                mul_b   = ig_mag[31:0];
                mul_neg = err_reg[32] ^ cfg.integ_gain[31];
            end
            SEL_IS: begin
                mul_a   = mag34(34'(ie_reg));
                mul_b   = {11'd0, dt_reg};
                mul_neg = ie_reg[31];
            end
            SEL_RQ: begin
                mul_a = {2'b00, num_reg[50:19]};
                mul_b = RECIP_US;
            end
            SEL_QC: begin
                mul_a = {2'b00, qest_reg};
                mul_b = {12'd0, US_PER_S};
            end
            default: ;
        endcase
    end

    assign rem_sh = {rem_reg[19:0], quo_reg[DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    // quotient estimate is low by at most three
    assign rem_us = num_reg - prod_reg[50:0];
    assign corr   = {1'b0, (rem_us >= 51'd1000000)} + {1'b0, (rem_us >= 51'd2000000)} +
                    {1'b0, (rem_us >= 51'd3000000)};
    assign qv     = {1'b0, qest_reg} + {31'd0, corr};

    always_comb begin
        isum    = 34'(integ_reg) + 34'(step_reg);
        cand    = ig_pos ? clamp34(isum, ilo, ihi) : 34'sd0;
        raw     = 34'(p_reg) + cand + 34'(d_reg);
        err_pos = !err_reg[32] && (err_reg != 33'sd0);
        deeper  = ((raw > lim) && err_pos) || ((raw < -lim) && err_reg[32]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            integ_reg   <= '0;
            last_reg    <= '0;
            restart_reg <= 1'b0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (cmd.op == OP_FIN) begin
                valid_reg <= 1'b1;
            end else if (valid_reg && out_ready) begin
                valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD: begin
                    pos_reg <= in_measured_pos;
                    dt_reg  <= dt_fix;
                    if (!in_kind) held_reg <= tgt;
                end
                OP_ERR: begin
                    err_reg     <= err_now;
                    diff_reg    <= 34'(err_now) - 34'(last_eff);
                    restart_reg <= 1'b0;
                end
                OP_MUL: begin
                    prod_reg     <= 66'(mul_a) * 66'(mul_b);
                    prod_neg_reg <= mul_neg;
                end
                OP_TAKE: begin
                    case (cmd.sel)
                        SEL_RATE: rate_reg <= (dt_reg > 21'd1) ?
                                  sat32(diff_reg[33], {10'd0, quo_reg}) : 32'sd0;
                        SEL_P:    p_reg  <= sat32(prod_neg_reg, {14'd0, prod_reg[65:16]});
                        SEL_D:    d_reg  <= sat32(prod_neg_reg, {14'd0, prod_reg[65:16]});
                        SEL_I:    ie_reg <= sat32(prod_neg_reg, {14'd0, prod_reg[65:16]});
                        SEL_IS:   num_reg <= prod_reg[50:0];
                        SEL_RQ:   qest_reg <= prod_reg[63:32];
                        SEL_QC:   step_reg <= ie_reg[31] ? (33'sd0 - $signed(qv)) : $signed(qv);
                        default: ;
                    endcase
                end
                OP_DIV_GO: begin
                    quo_reg <= prod_reg[DIV_W-1:0];
                    rem_reg <= '0;
                    den_reg <= dt_reg[19:0];
                    cnt_reg <= DIV_STEPS;
                end
                OP_DIV_STEP: begin
                    if (cnt_reg != 6'd0) begin
                        rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                        quo_reg <= {quo_reg[DIV_W-2:0], ge};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                OP_FIN: begin
                    if (!ig_pos) begin
                        integ_reg <= '0;
                    end else if (!deeper) begin
                        integ_reg <= cand[31:0];
                    end
                    last_reg  <= err_reg;
                    force_reg <= (raw > lim) ? lim[31:0] :
                                 (raw < -lim) ? 32'(-lim) : raw[31:0];
                    echo_reg  <= pos_reg;
                end
                default: ;
            endcase
            if (evt.ig_wr) begin
                if (evt.wdata[31] || (evt.wdata == 32'sd0)) begin
                    integ_reg <= '0;
                end else begin
                    integ_reg <= iclamp[31:0];
                end
            end
            if (evt.dg_wr) restart_reg <= 1'b1;
        end
    end

endmodule

// File: rtl/pid_position_controller_antiwindup.sv
// Top level of the PID position controller with anti-windup.
// Command item: taken while idle, no result. Tick item: error, rate product, the
// one-bit-per-cycle 54-step rate divider, then the P, D, I, integral-step and quotient steps.
// Throughput: one item at a time; the next item is taken once a tick's update finishes,
// later while a result waits on m_tready.
// Reset (aresetn low, synchronous): registers to defaults, state and result cleared.
module pid_position_controller_antiwindup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // target_cmd[31:0], measured_pos[63:32], elapsed_us[84:64]
    input  logic [0:0]  s_tuser,  // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // drive_force[31:0], pos_echo[63:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pidc_pkg::*;

    cfg_t               cfg;
    cfg_evt_t           evt;
    dp_cmd_t            cmd;
    dp_stat_t           stat;
    ctrl_state_t        state;
    logic signed [31:0] force_out, echo_out;

    pidc_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg, .evt
    );

    pidc_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_kind(s_tuser[0]), .s_tready,
        .stat, .cmd, .state
    );

    pidc_dp u_dp (
        .aclk, .aresetn, .cmd, .stat, .cfg, .evt,
        .in_kind(s_tuser[0]),
        .in_target_cmd(s_tdata[31:0]),
        .in_measured_pos(s_tdata[63:32]),
        .in_elapsed_us(s_tdata[84:64]),
        .out_drive_force(force_out),
        .out_pos_echo(echo_out),
        .out_valid(m_tvalid),
        .out_ready(m_tready)
    );

    assign m_tdata = {echo_out, force_out};

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state != ST_IDLE) |-> !s_tready)
        else $error("input taken while an update is running");

    a_fin_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIN) |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_TRATE) |-> stat.div_done)
        else $error("quotient taken before the divider finished");

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the PID position controller with anti-windup and force limit.
`timescale 1ns / 100ps

module testbench;
    import pidc_pkg::*;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] target_cmd;
        logic [31:0] measured_pos;
        logic [20:0] elapsed_us;
    } ctl_item_t;

    typedef struct packed {
        logic [31:0] pos_echo;
        logic [31:0] drive_force;
    } ctl_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pid_position_controller_antiwindup dut (.*);

    always #6 aclk = ~aclk;

    // controller model state
    longint kp, ki, kd, i_hi, i_lo, lim, t_lo, t_hi;
    longint tgt, iacc, prev_err;
    bit     d_restart;

    ctl_item_t   pending_items[$];
    ctl_result_t expected_forces[$];
    int          errors = 0;
    longint      cycles = 0;

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sat_mag(bit neg, longint unsigned m);
        if (neg) return (m > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(m);
        return (m > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(m);
    endfunction

    function automatic longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint qprod(longint a, longint b);
        return sat_mag((a < 0) != (b < 0), (absv(a) * absv(b)) >> 16);
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    task automatic model_reset();
        kp = 3932160; ki = 2621440; kd = 0; i_hi = 32768000; i_lo = -32768000;
        lim = 5242880; t_lo = -205887; t_hi = 0;
        tgt = 0; iacc = 0; prev_err = 0; d_restart = 0;
    endtask

    task automatic model_write(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_PROP_GAIN: kp = sx(v);
            REG_INTEG_GAIN: begin
                ki = sx(v);
                iacc = (ki <= 0) ? 0 : clampl(iacc, i_lo, i_hi);
            end
            REG_DERIV_GAIN: begin
                kd = sx(v);
                d_restart = 1;
            end
            REG_INTEG_UPPER: i_hi = sx(v);
            REG_INTEG_LOWER: i_lo = sx(v);
            REG_DRIVE_LIMIT: lim = longint'(v[30:0]);
            REG_TARGET_FLOOR: t_lo = sx(v);
            REG_TARGET_CEILING: t_hi = sx(v);
            default: ;
        endcase
    endtask

    task automatic predict_force(ctl_item_t it);
        longint lo, hi, pos, err, rate, p, d, ie, stp, cand, raw, frc;
        longint unsigned dt, m;
        ctl_result_t r;
        if (it.kind == KIND_CMD) begin
            lo = t_lo; hi = t_hi;
            if (lo > hi) begin lo = t_hi; hi = t_lo; end
            tgt = clampl(sx(it.target_cmd), lo, hi);
            return;
        end
        pos = sx(it.measured_pos);
        dt = it.elapsed_us;
        if (dt == 0 || dt > 1000000) dt = 1000;
        err = tgt - pos;
        if (d_restart) prev_err = err;
        d_restart = 0;
        rate = 0;
        if (dt > 1) begin
            m = absv(err - prev_err) * 1000000 / dt;
            rate = sat_mag((err - prev_err) < 0, m);
        end
        p = qprod(err, kp);
        d = qprod(rate, kd);
        if (ki > 0) begin
            ie = qprod(err, ki);
            m = absv(ie) * dt / 1000000;
            stp = ie < 0 ? -longint'(m) : longint'(m);
            cand = clampl(iacc + stp, i_lo, i_hi);
        end else begin
            cand = 0;
            iacc = 0;
        end
        raw = p + cand + d;
        frc = clampl(raw, -lim, lim);
        if (ki > 0 && !((raw > lim && err > 0) || (raw < -lim && err < 0))) iacc = cand;
        prev_err = err;
        r.drive_force = frc[31:0];
        r.pos_echo = pos[31:0];
        expected_forces.push_back(r);
    endtask

    // input handshake seen at the rising edge
    logic in_acc = 1'b0;
    always @(posedge aclk) begin
        in_acc <= aresetn && s_tvalid && s_tready;
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_acc) begin
                predict_force(pending_items.pop_front());
            end
            if (s_tvalid && !in_acc) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {3'b0, pending_items[0].elapsed_us,
                            pending_items[0].measured_pos, pending_items[0].target_cmd};
                s_tuser <= pending_items[0].kind;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(negedge aclk) begin
        if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 9) == 0);
            default: m_tready <= (cycles % 7) < 3;
        endcase
    end

    // monitor
    always @(posedge aclk) begin
        ctl_result_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_forces.size() == 0) begin
                $display("%0t unexpected transaction: actual %h", $time, got);
                errors = errors + 1;
            end else begin
                want = expected_forces.pop_front();
                if (got.drive_force !== want.drive_force) begin
                    $display("%0t drive_force: expected %h actual %h",
                             $time, want.drive_force, got.drive_force);
                    errors = errors + 1;
                end
                if (got.pos_echo !== want.pos_echo) begin
                    $display("%0t pos_echo: expected %h actual %h",
                             $time, want.pos_echo, got.pos_echo);
                    errors = errors + 1;
                end
            end
        end
        if (cycles > 64'd3_000_000) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        model_write(idx, v);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_forces.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 400000) - 200000;
            3: return $urandom_range(0, 20000000) - 10000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [20:0] rand_dt();
        case ($urandom_range(0, 7))
            0: return 21'd0;
            1: return 21'd1;
            2: return 21'($urandom);
            3: return 21'(1000000 + $urandom_range(0, 1));
            default: return 21'($urandom_range(100, 20000));
        endcase
    endfunction

    task automatic add_item(logic kind, logic [31:0] tc, logic [31:0] mp, logic [20:0] dt);
        ctl_item_t it;
        it.kind = kind; it.target_cmd = tc; it.measured_pos = mp; it.elapsed_us = dt;
        pending_items.push_back(it);
    endtask

    initial begin
        model_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_item(KIND_TICK, 0, 0, 0);
        add_item(KIND_TICK, 0, 32'h8000_0000, 1);
        add_item(KIND_TICK, 0, 32'h7FFF_FFFF, 21'h1FFFFF);
        add_item(KIND_CMD, 32'h8000_0000, 0, 0);
        add_item(KIND_TICK, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 21'd1000000);
        add_item(KIND_CMD, 32'h7FFF_FFFF, 0, 0);
        add_item(KIND_TICK, 0, 32'hFFFF_0000, 21'd1000001);
        add_item(KIND_CMD, -32'sd100000, 0, 0);
        add_item(KIND_TICK, 0, 32'h0001_0000, 21'd2);
        drain();
        reg_write(REG_TARGET_FLOOR, 32'd300000);
        reg_write(REG_TARGET_CEILING, -32'sd300000);
        reg_write(REG_DERIV_GAIN, 32'h7FFF_FFFF);
        reg_write(REG_INTEG_UPPER, -32'sd1000);
        reg_write(REG_INTEG_GAIN, 32'h0010_0000);
        add_item(KIND_CMD, 32'd500000, 0, 0);
        add_item(KIND_TICK, 0, 32'h8000_0000, 21'd500);
        add_item(KIND_TICK, 0, 32'h7FFF_FFFF, 21'd1);
        add_item(KIND_TICK, 0, 0, 21'd3);
        drain();
        reg_write(REG_INTEG_GAIN, 0);
        reg_write(REG_DRIVE_LIMIT, 32'h7FFF_FFFF);
        reg_write(REG_PROP_GAIN, 32'h8000_0000);
        reg_write(REG_DERIV_GAIN, 32'h8000_0000);
        add_item(KIND_TICK, 0, 32'h7FFF_FFFF, 21'd7);
        add_item(KIND_TICK, 0, 32'h8000_0000, 21'd1);
        drain();
        reg_write(REG_DRIVE_LIMIT, 0);
        reg_write(REG_INTEG_GAIN, 32'hFFFF_FFFF);
        add_item(KIND_TICK, 0, 32'h1234_5678, 21'd10);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 8; r++) begin
                if ($urandom_range(0, 2) != 0) begin
                    case (r)
                        REG_PROP_GAIN, REG_DERIV_GAIN, REG_INTEG_GAIN:
                            reg_write(r[2:0], ($urandom_range(0, 3) == 0) ? rand_word()
                                      : $urandom_range(0, 8000000) - 1000000);
                        REG_DRIVE_LIMIT:
                            reg_write(r[2:0], ($urandom_range(0, 3) == 0) ? rand_word()
                                      : $urandom_range(0, 20000000));
                        default: reg_write(r[2:0], rand_word());
                    endcase
                end
            end
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 4) == 0)
                    add_item(KIND_CMD, rand_word(), $urandom, 21'($urandom));
                else
                    add_item(KIND_TICK, $urandom, rand_word(), rand_dt());
            end
            drain();
        end

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
